>>> rtl/eeof_pkg.sv
package eeof_pkg;

   localparam int WORD_W   = 32;
   localparam int NORM_W   = 30;
   localparam int SQ_STEPS = 32;
   localparam int LEN_W    = 32;
   localparam int ACC_W    = 64;
   localparam int IN_DATA_W  = 224;
   localparam int OUT_DATA_W = 352;
   localparam logic [19:0] NEAR_SCALE = 20'd1000000;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      logic adv;
      logic valid;
   } pipe_ctl_type;

endpackage

>>> rtl/eeof_unit.sv
module eeof_unit
   import eeof_pkg::*;
#(
   parameter int LANES  = 3,
   parameter int IN_W   = 64,
   parameter int SIDE_W = 8,
   parameter int FRAC_W = 30
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pipe_ctl_type                   in_ctl,
   input  logic [LANES-1:0][IN_W-1:0]     in_vec,
   input  logic [SIDE_W-1:0]              in_side,
   output logic                           out_valid,
   output logic [LANES-1:0][WORD_W-1:0]   out_vec,
   output logic [SIDE_W-1:0]              out_side
);

   localparam int POS_W     = $clog2(IN_W);
   localparam int DIV_STEPS = FRAC_W + 1;
   localparam int Q_W       = FRAC_W + 1;
   localparam int CARRY_W   = SIDE_W + 1 + LANES + LANES * NORM_W;
   localparam int DC_W      = SIDE_W + 1 + LANES;
   localparam logic [POS_W-1:0] NORM_TOP = POS_W'(NORM_W - 1);

   // input capture
   logic [LANES-1:0][IN_W-1:0] va_ff;
   logic [SIDE_W-1:0]          sa_ff;
   logic                       a_vld_ff;

   // magnitudes
   logic [LANES-1:0][IN_W-1:0] mb_ff, mb_in;
   logic [LANES-1:0]           nb_ff, nb_in;
   logic [IN_W-1:0]            ob_ff, ob_in;
   logic [SIDE_W-1:0]          sb_ff;
   logic                       b_vld_ff;

   // leading one position
   logic [POS_W-1:0]           pc_ff, pc_in;
   logic                       zc_ff;
   logic [LANES-1:0][IN_W-1:0] mc_ff;
   logic [LANES-1:0]           nc_ff;
   logic [SIDE_W-1:0]          sc_ff;
   logic                       c_vld_ff;

   // normalised magnitudes
   logic [LANES-1:0][NORM_W-1:0] dd_ff, dd_in;
   logic [LANES-1:0]             nd_ff;
   logic                         zd_ff;
   logic [SIDE_W-1:0]            sd_ff;
   logic                         d_vld_ff;

   // squares
   logic [LANES-1:0][2*NORM_W-1:0] qe_ff;
   logic [CARRY_W-1:0]             ce_ff;
   logic                           e_vld_ff;

   // square root, one result bit per stage
   logic [ACC_W-1:0]   sv_ff [SQ_STEPS+1];
   logic [ACC_W-1:0]   sv_in [SQ_STEPS+1];
   logic [ACC_W-1:0]   sr_ff [SQ_STEPS+1];
   logic [ACC_W-1:0]   sr_in [SQ_STEPS+1];
   logic [CARRY_W-1:0] cw_ff [SQ_STEPS+1];
   logic               sq_vld_ff [SQ_STEPS+1];

   // restoring division, one quotient bit per stage
   logic [LANES-1:0][ACC_W-1:0] dr_ff [DIV_STEPS+1];
   logic [LANES-1:0][ACC_W-1:0] dr_in [DIV_STEPS+1];
   logic [LANES-1:0][Q_W-1:0]   dq_ff [DIV_STEPS+1];
   logic [LANES-1:0][Q_W-1:0]   dq_in [DIV_STEPS+1];
   logic [LEN_W-1:0]            dl_ff [DIV_STEPS+1];
   logic [LEN_W-1:0]            dl_in [DIV_STEPS+1];
   logic [DC_W-1:0]             dc_ff [DIV_STEPS+1];
   logic [DC_W-1:0]             dc_in [DIV_STEPS+1];
   logic                        dv_ff [DIV_STEPS+1];

   // output stage
   logic [LANES-1:0][WORD_W-1:0] ov_ff, ov_in;
   logic [SIDE_W-1:0]            os_ff;
   logic                         o_vld_ff;

   always_comb begin
      ob_in = '0;
      for (int l = 0; l < LANES; l++) begin
         nb_in[l] = va_ff[l][IN_W-1];
         mb_in[l] = nb_in[l] ? (~va_ff[l] + IN_W'(1)) : va_ff[l];
         ob_in    = ob_in | mb_in[l];
      end
   end

   // the or of all magnitudes has its top bit where the largest one has
   always_comb begin
      pc_in = '0;
      for (int i = 0; i < IN_W; i++) begin
         if (ob_ff[i]) begin
            pc_in = POS_W'(i);
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (pc_ff >= NORM_TOP) begin
            dd_in[l] = NORM_W'(mc_ff[l] >> (pc_ff - NORM_TOP));
         end else begin
            dd_in[l] = mc_ff[l][NORM_W-1:0] << (NORM_TOP - pc_ff);
         end
      end
   end

   always_comb begin
      logic [ACC_W-1:0] sum;
      logic [ACC_W-1:0] bitv;
      logic [ACC_W-1:0] trial;
      logic [LEN_W-1:0] len;
      logic [ACC_W-1:0] dsh;
      sum = '0;
      for (int l = 0; l < LANES; l++) begin
         sum = sum + ACC_W'(qe_ff[l]);
      end
      sv_in[0] = sum;
      sr_in[0] = '0;
      for (int j = 0; j < SQ_STEPS; j++) begin
         bitv  = ACC_W'(1) << (2 * (SQ_STEPS - 1 - j));
         trial = sr_ff[j] + bitv;
         if (sv_ff[j] >= trial) begin
            sv_in[j+1] = sv_ff[j] - trial;
            sr_in[j+1] = (sr_ff[j] >> 1) + bitv;
         end else begin
            sv_in[j+1] = sv_ff[j];
            sr_in[j+1] = sr_ff[j] >> 1;
         end
      end

      // round the root to nearest, then set up the dividend
      len = sr_ff[SQ_STEPS][LEN_W-1:0]
            + LEN_W'(sv_ff[SQ_STEPS] > sr_ff[SQ_STEPS]);
      dl_in[0] = len;
      dc_in[0] = cw_ff[SQ_STEPS][CARRY_W-1:LANES*NORM_W];
      for (int l = 0; l < LANES; l++) begin
         dr_in[0][l] = (ACC_W'(cw_ff[SQ_STEPS][l*NORM_W +: NORM_W]) << FRAC_W)
                       + ACC_W'(len >> 1);
         dq_in[0][l] = '0;
      end

      for (int j = 0; j < DIV_STEPS; j++) begin
         dl_in[j+1] = dl_ff[j];
         dc_in[j+1] = dc_ff[j];
         dsh = ACC_W'(dl_ff[j]) << (FRAC_W - j);
         for (int l = 0; l < LANES; l++) begin
            if (dr_ff[j][l] >= dsh) begin
               dr_in[j+1][l] = dr_ff[j][l] - dsh;
               dq_in[j+1][l] = dq_ff[j][l] | (Q_W'(1) << (FRAC_W - j));
            end else begin
               dr_in[j+1][l] = dr_ff[j][l];
               dq_in[j+1][l] = dq_ff[j][l];
            end
         end
      end

      for (int l = 0; l < LANES; l++) begin
         if (dc_ff[DIV_STEPS][LANES]) begin
            ov_in[l] = '0;
         end else if (dc_ff[DIV_STEPS][l]) begin
            ov_in[l] = ~WORD_W'(dq_ff[DIV_STEPS][l]) + WORD_W'(1);
         end else begin
            ov_in[l] = WORD_W'(dq_ff[DIV_STEPS][l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
         for (int j = 0; j <= SQ_STEPS; j++) begin
            sq_vld_ff[j] <= 1'b0;
         end
         for (int j = 0; j <= DIV_STEPS; j++) begin
            dv_ff[j] <= 1'b0;
         end
      end else if (in_ctl.adv) begin
         a_vld_ff     <= in_ctl.valid;
         b_vld_ff     <= a_vld_ff;
         c_vld_ff     <= b_vld_ff;
         d_vld_ff     <= c_vld_ff;
         e_vld_ff     <= d_vld_ff;
         sq_vld_ff[0] <= e_vld_ff;
         for (int j = 0; j < SQ_STEPS; j++) begin
            sq_vld_ff[j+1] <= sq_vld_ff[j];
         end
         dv_ff[0] <= sq_vld_ff[SQ_STEPS];
         for (int j = 0; j < DIV_STEPS; j++) begin
            dv_ff[j+1] <= dv_ff[j];
         end
         o_vld_ff <= dv_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctl.adv) begin
         va_ff <= in_vec;
         sa_ff <= in_side;
         mb_ff <= mb_in;
         nb_ff <= nb_in;
         ob_ff <= ob_in;
         sb_ff <= sa_ff;
         pc_ff <= pc_in;
         zc_ff <= (ob_ff == '0);
         mc_ff <= mb_ff;
         nc_ff <= nb_ff;
         sc_ff <= sb_ff;
         dd_ff <= dd_in;
         nd_ff <= nc_ff;
         zd_ff <= zc_ff;
         sd_ff <= sc_ff;
         for (int l = 0; l < LANES; l++) begin
            qe_ff[l] <= dd_ff[l] * dd_ff[l];
         end
         ce_ff <= {sd_ff, zd_ff, nd_ff, dd_ff};
         cw_ff[0] <= ce_ff;
         for (int j = 0; j <= SQ_STEPS; j++) begin
            sv_ff[j] <= sv_in[j];
            sr_ff[j] <= sr_in[j];
         end
         for (int j = 0; j < SQ_STEPS; j++) begin
            cw_ff[j+1] <= cw_ff[j];
         end
         for (int j = 0; j <= DIV_STEPS; j++) begin
            dr_ff[j] <= dr_in[j];
            dq_ff[j] <= dq_in[j];
            dl_ff[j] <= dl_in[j];
            dc_ff[j] <= dc_in[j];
         end
         ov_ff <= ov_in;
         os_ff <= dc_ff[DIV_STEPS][DC_W-1 -: SIDE_W];
      end
   end

   assign out_valid = o_vld_ff;
   assign out_vec   = ov_ff;
   assign out_side  = os_ff;

endmodule

>>> rtl/edge_end_orientation_frame_core.sv
// edge end orientation frame
// one request on req_ carries a source point, a destination point and a glyph
// length; one response on rsp_ returns the unit direction, a unit vector
// perpendicular to it, their normalised cross product and the anchor point
// (destination moved back by half the glyph length along the direction).
// no state links requests, so a request is taken in every cycle that the
// pipeline moves, and one response leaves per cycle while it moves.
// three normalising units run in a row, each with a 32 stage square root
// and a UNIT_FRAC_BITS + 1 stage divider, plus one anchor stage and one
// multiplier stage for the cross product.
// the whole pipeline advances together; when rsp_tvalid is high and
// rsp_tready low the pipeline holds and req_tready drops, nothing is lost.
// synchronous reset empties the pipeline: rsp_tvalid is low in the cycle
// after reset.
module edge_end_orientation_frame_core
   import eeof_pkg::*;
#(
   parameter int UNIT_FRAC_BITS = 30
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z, glyph_length, zero fill
   input  logic [IN_DATA_W-1:0]  req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // dir_x, dir_y, dir_z, perp_y, perp_z, side_x, side_y, side_z,
   // anchor_x, anchor_y, anchor_z
   output logic [OUT_DATA_W-1:0] rsp_tdata
);

   localparam logic [WORD_W-1:0] UNIT_ONE = WORD_W'(1) << UNIT_FRAC_BITS;
   localparam logic [51:0] NEAR_LIMIT = 52'(1) << UNIT_FRAC_BITS;
   localparam logic [62:0] ROUND_HALF = 63'(1) << UNIT_FRAC_BITS;

   logic         adv;
   pipe_ctl_type ctl1, ctl2, ctl3;

   // first unit: direction
   logic [2:0][32:0]     diff;
   logic [126:0]         u1_side_in, u1_side;
   logic                 u1_vld;
   logic [2:0][WORD_W-1:0] u1_dir;

   // anchor and perpendicular setup
   logic [2:0][WORD_W-1:0] p1_dir_ff, p1_end_ff;
   logic [2:0][62:0]       p1_prod_ff;
   logic [2:0]             p1_neg_ff;
   logic                   p1_nzy_ff, p1_nzz_ff;
   logic                   p1_vld_ff;
   logic [2:0][WORD_W-1:0] dmag;

   logic [2:0][WORD_W-1:0] anchor;
   logic [1:0][33:0]       pv;
   logic                   flip;
   logic [WORD_W-1:0]      fix_y, fix_z;
   logic [256:0]           u2_side_in, u2_side;
   logic                   u2_vld;
   logic [1:0][WORD_W-1:0] u2_perp;

   // cross product products
   logic [2:0][WORD_W-1:0] m_dir_ff, m_anc_ff;
   logic [1:0][WORD_W-1:0] m_perp_ff, m_perp_in;
   logic [63:0]            m_pyz_ff, m_pzy_ff, m_pxz_ff, m_pxy_ff;
   logic                   m_vld_ff;

   logic [2:0][63:0]       crs;
   logic [255:0]           u3_side_in, u3_side;
   logic                   u3_vld;
   logic [2:0][WORD_W-1:0] u3_vec;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   assign ctl1 = '{adv: adv, valid: req_tvalid};
   assign ctl2 = '{adv: adv, valid: p1_vld_ff};
   assign ctl3 = '{adv: adv, valid: m_vld_ff};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = {req_tdata[(i+3)*32+31], req_tdata[(i+3)*32 +: 32]}
                   - {req_tdata[i*32+31], req_tdata[i*32 +: 32]};
      end
   end
   assign u1_side_in = {req_tdata[222:192], req_tdata[191:96]};

   eeof_unit #(
      .LANES  (3),
      .IN_W   (33),
      .SIDE_W (127),
      .FRAC_W (UNIT_FRAC_BITS)
   ) u_dir (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (ctl1),
      .in_vec    (diff),
      .in_side   (u1_side_in),
      .out_valid (u1_vld),
      .out_vec   (u1_dir),
      .out_side  (u1_side)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dmag[i] = u1_dir[i][WORD_W-1] ? (~u1_dir[i] + WORD_W'(1)) : u1_dir[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         m_vld_ff  <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= u1_vld;
         m_vld_ff  <= u2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_dir_ff <= u1_dir;
         p1_end_ff <= u1_side[95:0];
         for (int i = 0; i < 3; i++) begin
            p1_prod_ff[i] <= 63'(u1_side[126:96]) * 63'(dmag[i]);
            p1_neg_ff[i]  <= u1_dir[i][WORD_W-1];
         end
         p1_nzy_ff <= (52'(dmag[1]) * 52'(NEAR_SCALE)) < NEAR_LIMIT;
         p1_nzz_ff <= (52'(dmag[2]) * 52'(NEAR_SCALE)) < NEAR_LIMIT;
      end
   end

   // anchor: end minus half length along dir, rounded half away, saturated
   always_comb begin
      logic [62:0]        off;
      logic signed [63:0] sum;
      for (int i = 0; i < 3; i++) begin
         off = (p1_prod_ff[i] + ROUND_HALF) >> (UNIT_FRAC_BITS + 1);
         if (p1_neg_ff[i]) begin
            sum = 64'($signed(p1_end_ff[i])) + $signed(64'(off));
         end else begin
            sum = 64'($signed(p1_end_ff[i])) - $signed(64'(off));
         end
         if (sum > 64'sd2147483647) begin
            anchor[i] = 32'h7fffffff;
         end else if (sum < -64'sd2147483648) begin
            anchor[i] = 32'h80000000;
         end else begin
            anchor[i] = sum[31:0];
         end
      end
   end

   // general case: sign(dy*dz) * (dz, -dy), normalised; else the z axis if dz is near zero, or the y axis
   always_comb begin
      flip  = p1_dir_ff[1][WORD_W-1] != p1_dir_ff[2][WORD_W-1];
      pv[0] = flip ? -34'($signed(p1_dir_ff[2])) : 34'($signed(p1_dir_ff[2]));
      pv[1] = flip ? 34'($signed(p1_dir_ff[1])) : -34'($signed(p1_dir_ff[1]));
      if (p1_nzz_ff) begin
         fix_y = '0;
         fix_z = UNIT_ONE;
      end else begin
         fix_y = UNIT_ONE;
         fix_z = '0;
      end
   end

   assign u2_side_in = {!p1_nzz_ff && !p1_nzy_ff, fix_z, fix_y, anchor, p1_dir_ff};

   eeof_unit #(
      .LANES  (2),
      .IN_W   (34),
      .SIDE_W (257),
      .FRAC_W (UNIT_FRAC_BITS)
   ) u_perp (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (ctl2),
      .in_vec    (pv),
      .in_side   (u2_side_in),
      .out_valid (u2_vld),
      .out_vec   (u2_perp),
      .out_side  (u2_side)
   );

   assign m_perp_in = u2_side[256] ? u2_perp : u2_side[255:192];

   always_ff @(posedge clock) begin
      if (adv) begin
         m_dir_ff  <= u2_side[95:0];
         m_anc_ff  <= u2_side[191:96];
         m_perp_ff <= m_perp_in;
         m_pyz_ff  <= 64'($signed(u2_side[63:32])) * 64'($signed(m_perp_in[1]));
         m_pzy_ff  <= 64'($signed(u2_side[95:64])) * 64'($signed(m_perp_in[0]));
         m_pxz_ff  <= 64'($signed(u2_side[31:0])) * 64'($signed(m_perp_in[1]));
         m_pxy_ff  <= 64'($signed(u2_side[31:0])) * 64'($signed(m_perp_in[0]));
      end
   end

   assign crs[0]     = m_pyz_ff - m_pzy_ff;
   assign crs[1]     = ~m_pxz_ff + 64'(1);
   assign crs[2]     = m_pxy_ff;
   assign u3_side_in = {m_anc_ff, m_perp_ff, m_dir_ff};

   eeof_unit #(
      .LANES  (3),
      .IN_W   (64),
      .SIDE_W (256),
      .FRAC_W (UNIT_FRAC_BITS)
   ) u_side (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (ctl3),
      .in_vec    (crs),
      .in_side   (u3_side_in),
      .out_valid (u3_vld),
      .out_vec   (u3_vec),
      .out_side  (u3_side)
   );

   assign rsp_tvalid = u3_vld;
   assign rsp_tdata  = {u3_side[255:160], u3_vec, u3_side[159:96], u3_side[95:0]};

   // an all zero perp_y only comes from the z axis choice
   a_perp_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[127:96] == '0 |-> rsp_tdata[159:128] == UNIT_ONE)
      else $error("perp_y zero without unit z perpendicular");

   // a zero direction gives a zero side axis
   a_zero_side: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[95:0] == '0 |-> rsp_tdata[255:160] == '0)
      else $error("side axis not zero for zero direction");

   a_perp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[159:128]) <= $signed(UNIT_ONE)
                  && $signed(rsp_tdata[159:128]) >= -$signed(UNIT_ONE))
      else $error("perp_z beyond unit magnitude");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

>>> tb/sv/edge_end_orientation_frame_core_tb.sv
module edge_end_orientation_frame_core_tb
   import eeof_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int UFB         = 30;
   localparam int LATENCY     = 3 * UFB + 125;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_LEN    = 2 * LATENCY;
   localparam int RAND_ITEMS  = 125;

   localparam logic [31:0] MAX_POS = 32'h7fffffff;
   localparam logic [31:0] MAX_NEG = 32'h80000000;
   localparam logic [30:0] GLYPH_MAX = 31'h7fffffff;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // start_x, start_y, start_z, end_x, end_y, end_z, glyph_length, zero fill
   logic [IN_DATA_W-1:0]  req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // dir_x, dir_y, dir_z, perp_y, perp_z, side_x, side_y, side_z,
   // anchor_x, anchor_y, anchor_z
   logic [OUT_DATA_W-1:0] rsp_tdata;

   logic [OUT_DATA_W-1:0] frame_fifo[$];
   int  send_idle_pct;
   int  recv_idle_pct;
   int  hold_request;
   int  hold_left;
   int  stall_count;
   int  error_count;
   int  frames_sent;
   int  frames_checked;
   int  degenerate_sent;

   string field_name[11] = '{"dir_x", "dir_y", "dir_z", "perp_y", "perp_z",
                             "side_x", "side_y", "side_z",
                             "anchor_x", "anchor_y", "anchor_z"};

   edge_end_orientation_frame_core #(.UNIT_FRAC_BITS(UFB)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? 64'd0 - longint'(v) : longint'(v);
   endfunction

   function automatic longint unsigned isqrt_round(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      if (v > res) res++;
      return res;
   endfunction

   // block-floating scale to [2^29, 2^30), then divide by the rounded length
   task automatic normalise(input longint vin[3], input int n, output longint vout[3]);
      longint unsigned m[3];
      longint unsigned top;
      longint unsigned sum;
      longint unsigned len;
      longint unsigned q;
      int rs;
      int ls;
      top = 0;
      sum = 0;
      rs  = 0;
      ls  = 0;
      vout = '{0, 0, 0};
      for (int i = 0; i < n; i++) begin
         m[i] = magnitude(vin[i]);
         if (m[i] > top) top = m[i];
      end
      if (top != 0) begin
         while (top >= (64'd1 << 30)) begin
            top >>= 1;
            rs++;
         end
         while (top < (64'd1 << 29)) begin
            top <<= 1;
            ls++;
         end
         for (int i = 0; i < n; i++) begin
            m[i] = (m[i] >> rs) << ls;
            sum  = sum + m[i] * m[i];
         end
         len = isqrt_round(sum);
         for (int i = 0; i < n; i++) begin
            q = ((m[i] << UFB) + len / 2) / len;
            vout[i] = vin[i] < 0 ? -longint'(q) : longint'(q);
         end
      end
   endtask

   function automatic bit near_zero(longint u);
      return magnitude(u) * 64'd1000000 < (64'd1 << UFB);
   endfunction

   task automatic predict_frame(input logic [IN_DATA_W-1:0] d,
                                output logic [OUT_DATA_W-1:0] r);
      longint endp[3];
      longint diff[3];
      longint dir[3];
      longint perp[3];
      longint crs[3];
      longint side[3];
      longint v[3];
      longint pr[3];
      longint off;
      longint anc;
      longint unsigned glen;
      longint unsigned prod;
      bit flip;
      glen = longint'(d[222:192]);
      for (int i = 0; i < 3; i++) begin
         endp[i] = longint'(signed'(d[32*(3+i) +: 32]));
         diff[i] = endp[i] - longint'(signed'(d[32*i +: 32]));
      end
      normalise(diff, 3, dir);
      perp[0] = 0;
      if (near_zero(dir[2])) begin
         perp[1] = 0;
         perp[2] = longint'(1) << UFB;
      end else if (near_zero(dir[1])) begin
         perp[1] = longint'(1) << UFB;
         perp[2] = 0;
      end else begin
         flip = (dir[1] < 0) != (dir[2] < 0);
         v[0] = flip ? -dir[2] : dir[2];
         v[1] = flip ? dir[1] : -dir[1];
         v[2] = 0;
         normalise(v, 2, pr);
         perp[1] = pr[0];
         perp[2] = pr[1];
      end
      crs[0] = dir[1] * perp[2] - dir[2] * perp[1];
      crs[1] = -(dir[0] * perp[2]);
      crs[2] = dir[0] * perp[1];
      normalise(crs, 3, side);
      for (int i = 0; i < 3; i++) begin
         prod = glen * magnitude(dir[i]);
         off  = longint'((prod + (64'd1 << UFB)) >> (UFB + 1));
         if (dir[i] < 0) off = -off;
         anc = endp[i] - off;
         if (anc > 64'sd2147483647) anc = 64'sd2147483647;
         if (anc < -64'sd2147483648) anc = -64'sd2147483648;
         r[32*(8+i) +: 32] = anc[31:0];
         r[32*i +: 32]     = dir[i][31:0];
         r[32*(5+i) +: 32] = side[i][31:0];
      end
      r[32*3 +: 32] = perp[1][31:0];
      r[32*4 +: 32] = perp[2][31:0];
   endtask

   function automatic logic [IN_DATA_W-1:0] pack_request(logic [31:0] s[3], logic [31:0] e[3],
                                                         logic [30:0] glyph);
      return {1'b0, glyph, e[2], e[1], e[0], s[2], s[1], s[0]};
   endfunction

   // receiver: random stalls, or a counted hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_request > 0) begin
         rsp_tready   <= 1'b0;
         hold_left    <= hold_request;
         hold_request = 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // scoreboard and watchdog
   always @(posedge clock) begin
      logic [OUT_DATA_W-1:0] want;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_frame(req_tdata, want);
            frame_fifo.push_back(want);
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (frame_fifo.size() == 0) begin
               $display("%0t: response with no request outstanding: %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = frame_fifo.pop_front();
               for (int f = 0; f < 11; f++)
                  if (rsp_tdata[32*f +: 32] !== want[32*f +: 32]) begin
                     $display("%0t: %s mismatch, expected %h actual %h", $time,
                              field_name[f], want[32*f +: 32], rsp_tdata[32*f +: 32]);
                     error_count++;
                  end
            end
            frames_checked++;
         end
         stall_count = moved ? 0 : stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [IN_DATA_W-1:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      frames_sent++;
      if (d[32*3 +: 96] == d[0 +: 96]) degenerate_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_points(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                              logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                              logic [30:0] glyph);
      logic [31:0] s[3];
      logic [31:0] e[3];
      s = '{sx, sy, sz};
      e = '{ex, ey, ez};
      send_request(pack_request(s, e, glyph));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (frame_fifo.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] near_value(logic [31:0] base);
      return base + 32'(signed'($urandom_range(4000)) - 2000);
   endfunction

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(3))
         0: return MAX_POS;
         1: return MAX_NEG;
         2: return 32'd0;
         default: return 32'hffffffff;
      endcase
   endfunction

   function automatic logic [IN_DATA_W-1:0] random_request();
      logic [31:0] s[3];
      logic [31:0] e[3];
      logic [30:0] glyph;
      int mode;
      int axis;
      mode = $urandom_range(9);
      axis = $urandom_range(2);
      for (int i = 0; i < 3; i++) begin
         s[i] = $urandom;
         e[i] = $urandom;
      end
      case (mode)
         4, 5: for (int i = 0; i < 3; i++) e[i] = near_value(s[i]);
         6: begin
            // one long axis, the others zero or tiny
            for (int i = 0; i < 3; i++)
               if (i != axis) e[i] = s[i] + 32'($urandom_range(2)) - 32'd1;
         end
         7: e = s;
         8: for (int i = 0; i < 3; i++) begin
            s[i] = pick_extreme();
            e[i] = pick_extreme();
         end
         9: e[1] = s[1] + 32'($urandom_range(1));
         default: ;
      endcase
      case ($urandom_range(7))
         0: glyph = 31'd0;
         1: glyph = GLYPH_MAX;
         2: glyph = 31'($urandom_range(1 << 20));
         default: glyph = 31'($urandom);
      endcase
      return pack_request(s, e, glyph);
   endfunction

   task automatic test_directed();
      send_points(0, 0, 0, 0, 0, 0, 0);
      send_points(5, 6, 7, 5, 6, 7, GLYPH_MAX);
      send_points(MAX_NEG, MAX_NEG, MAX_NEG, MAX_POS, MAX_POS, MAX_POS, GLYPH_MAX);
      send_points(MAX_POS, MAX_POS, MAX_POS, MAX_NEG, MAX_NEG, MAX_NEG, GLYPH_MAX);
      send_points(0, 0, 0, 32'h00010000, 0, 0, 31'h00020000);
      send_points(0, 0, 0, 0, 32'h00010000, 0, 31'h00020000);
      send_points(0, 0, 0, 0, 0, 32'h00010000, 31'h00020000);
      send_points(0, 0, 0, 0, 0, 32'hffff0000, 31'h00030000);
      // z tiny against a huge x: the z offset is not zero, but the scaling drops it
      send_points(MAX_NEG, 0, 0, MAX_POS, 0, 1, 31'h1234);
      // y tiny, z large: falls to the y axis perpendicular
      send_points(MAX_NEG, 0, 0, MAX_POS, 1, 32'h00400000, 31'h1234);
      send_points(0, 0, 0, 32'h00010000, 32'h00010000, 32'h00010000, 31'h1);
      send_points(0, 0, 0, 32'hffff0000, 32'h00010000, 32'hffff0000, 31'h3);
      send_points(0, 0, 0, 32'h00010000, 32'hffff0000, 32'h00020000, GLYPH_MAX);
      // anchor saturation at both ends
      send_points(MAX_POS, 0, 0, 32'h7ffff000, 0, 0, GLYPH_MAX);
      send_points(MAX_NEG, 0, 0, 32'h80001000, 0, 0, GLYPH_MAX);
      send_points(0, 0, 0, 1, 0, 0, 31'd1);
      send_points(0, 0, 0, 32'hffffffff, 0, 0, 31'd1);
      send_points(0, 0, 0, 3, 5, 7, 31'd3);
      wait_drained();
   endtask

   task automatic test_random(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (RAND_ITEMS) send_request(random_request());
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = HOLD_LEN;
      repeat (LATENCY + 40) send_request(random_request());
      wait_drained();
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 0;
      stall_count   = 0;
      error_count   = 0;
      frames_sent   = 0;
      frames_checked = 0;
      degenerate_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(10, 45);
      test_random(45, 10);
      test_backpressure();
      test_random(0, 0);
      repeat (LATENCY + 20) @(posedge clock);
      $display("%0d requests sent (%0d with equal end points), %0d responses checked,",
               frames_sent, degenerate_sent, frames_checked);
      $display("stalls on both sides and one long receiver hold-off filling the pipeline");
      if (error_count == 0 && frame_fifo.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/eeof_pkg.sv
rtl/eeof_unit.sv
rtl/edge_end_orientation_frame_core.sv
tb/sv/edge_end_orientation_frame_core_tb.sv
